FILE: rtl/crpe_pkg.sv
// shared types and constants of the catmull-rom point evaluator
package crpe_pkg;

    // sizes of the data path
    localparam int MAX_POINTS    = 16;
    localparam int COORD_BITS    = 16;
    localparam int FRACTION_BITS = 16;
    localparam int PARAM_BITS    = 20;
    localparam int COUNT_BITS    = 5;
    localparam int IDX_BITS      = $clog2(MAX_POINTS);
    localparam int SEG_BITS      = PARAM_BITS - FRACTION_BITS;

    // four taps per segment, one table bank per tap
    localparam int NUM_TAPS      = 4;
    localparam int TAP_BITS      = 2;
    localparam int BANK_DEPTH    = MAX_POINTS / NUM_TAPS;
    localparam int BANK_BITS     = IDX_BITS - TAP_BITS;

    // queue between front and back
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS    = $clog2(Q_DEPTH + 1);

    // reset value of the point count
    localparam logic [COUNT_BITS-1:0] POINT_COUNT_RESET = COUNT_BITS'(4);

    // item operation codes
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } t_op;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // one evaluate item as handed from front to back
    typedef struct packed {
        t_coord [NUM_TAPS-1:0]    px;
        t_coord [NUM_TAPS-1:0]    py;
        logic [FRACTION_BITS-1:0] frac;
        logic                     oor;
    } t_q_entry;

    // queue fill status
    typedef struct packed {
        logic [Q_CNT_BITS-1:0] count;
        logic                  not_empty;
    } t_q_status;

endpackage

FILE: rtl/crpe_ifs.sv
// channel interfaces: input items, result items, configuration writes

interface crpe_in_if;
    import crpe_pkg::*;
    logic                  valid;
    logic                  ready;
    t_op                   operation;
    logic [IDX_BITS-1:0]   point_index;
    t_coord                point_x;
    t_coord                point_y;
    logic [PARAM_BITS-1:0] curve_param;

    modport source (output valid, operation, point_index, point_x, point_y, curve_param,
                    input ready);
    modport sink   (input valid, operation, point_index, point_x, point_y, curve_param,
                    output ready);
endinterface

interface crpe_out_if;
    import crpe_pkg::*;
    logic   valid;
    logic   ready;
    t_coord curve_x;
    t_coord curve_y;
    logic   out_of_range;

    modport source (output valid, curve_x, curve_y, out_of_range, input ready);
    modport sink   (input valid, curve_x, curve_y, out_of_range, output ready);
endinterface

interface crpe_cfg_if;
    import crpe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/crpe_front.sv
// front end: item accept, banked point table, segment range check
module crpe_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    crpe_in_if.sink              i_item,
    crpe_cfg_if.sink             i_cfg,
    input  crpe_pkg::t_q_status  i_q_status,
    output logic                 o_push,
    output crpe_pkg::t_q_entry   o_entry
);
    import crpe_pkg::*;

    logic [COUNT_BITS-1:0]         r_point_count;
    logic                          r_s1_valid;
    logic [TAP_BITS-1:0]           r_rot;
    logic [FRACTION_BITS-1:0]      r_frac;
    logic                          r_oor;
    logic [2*COORD_BITS-1:0]       r_bank [NUM_TAPS][BANK_DEPTH];
    logic [2*COORD_BITS-1:0]       r_rd   [NUM_TAPS];

    logic                          accept;
    logic                          is_eval;
    logic [SEG_BITS-1:0]           seg;
    logic [TAP_BITS-1:0]           seg_lo;
    logic [BANK_BITS-1:0]          seg_hi;
    logic [COUNT_BITS-1:0]         eff_count;
    logic                          oor;
    logic [BANK_BITS-1:0]          bank_addr [NUM_TAPS];
    logic [Q_CNT_BITS-1:0]         used;

    // configuration is always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= POINT_COUNT_RESET;
        end else if (i_cfg.valid) begin
            r_point_count <= i_cfg.data;
        end
    end

    // queue slots held or reserved by the read stage
    assign used         = i_q_status.count + Q_CNT_BITS'(r_s1_valid);
    assign i_item.ready = used < Q_CNT_BITS'(Q_DEPTH);
    assign accept       = i_item.valid && i_item.ready;
    assign is_eval      = i_item.operation == OP_EVAL;

    // segment split and range check against the clamped point count
    assign seg    = i_item.curve_param[PARAM_BITS-1:FRACTION_BITS];
    assign seg_lo = seg[TAP_BITS-1:0];
    assign seg_hi = seg[IDX_BITS-1:TAP_BITS];

    always_comb begin
        if (r_point_count > COUNT_BITS'(MAX_POINTS)) begin
            eff_count = COUNT_BITS'(MAX_POINTS);
        end else begin
            eff_count = r_point_count;
        end
        oor = ({1'b0, seg} + (SEG_BITS+1)'(NUM_TAPS)) >
              (SEG_BITS+1)'(eff_count);
    end

    // each bank holds one tap of the segment; lower banks wrap to the next row
    always_comb begin
        for (int b = 0; b < NUM_TAPS; b++) begin
            if (TAP_BITS'(b) < seg_lo) begin
                bank_addr[b] = seg_hi + BANK_BITS'(1);
            end else begin
                bank_addr[b] = seg_hi;
            end
        end
    end

    // point table write and registered bank reads
    always_ff @(posedge i_clk) begin
        if (accept && !is_eval) begin
            r_bank[i_item.point_index[TAP_BITS-1:0]][i_item.point_index[IDX_BITS-1:TAP_BITS]]
                <= {i_item.point_x, i_item.point_y};
        end
        if (accept && is_eval) begin
            for (int b = 0; b < NUM_TAPS; b++) begin
                r_rd[b] <= r_bank[b][bank_addr[b]];
            end
            r_rot  <= seg_lo;
            r_frac <= i_item.curve_param[FRACTION_BITS-1:0];
            r_oor  <= oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept && is_eval;
        end
    end

    // rotate bank data into tap order and push
    always_comb begin
        for (int i = 0; i < NUM_TAPS; i++) begin
            o_entry.px[i] = r_rd[r_rot + TAP_BITS'(i)][2*COORD_BITS-1:COORD_BITS];
            o_entry.py[i] = r_rd[r_rot + TAP_BITS'(i)][COORD_BITS-1:0];
        end
        o_entry.frac = r_frac;
        o_entry.oor  = r_oor;
    end

    assign o_push = r_s1_valid;

endmodule

FILE: rtl/crpe_queue.sv
// short fifo between front and back
module crpe_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  crpe_pkg::t_q_entry   i_entry,
    input  logic                 i_pop,
    output crpe_pkg::t_q_entry   o_entry,
    output crpe_pkg::t_q_status  o_status
);
    import crpe_pkg::*;

    t_q_entry              r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_BITS'(1);
            end
            r_count <= r_count + Q_CNT_BITS'(i_push) - Q_CNT_BITS'(i_pop);
        end
    end

    assign o_entry            = r_mem[r_rd_ptr];
    assign o_status.count     = r_count;
    assign o_status.not_empty = r_count != '0;

endmodule

FILE: rtl/crpe_back.sv
// back end: cubic weights, tap products, sum, round and saturate
module crpe_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  crpe_pkg::t_q_status  i_q_status,
    input  crpe_pkg::t_q_entry   i_entry,
    output logic                 o_pop,
    crpe_out_if.source           o_result
);
    import crpe_pkg::*;

    localparam int W_BITS    = FRACTION_BITS + 4;
    localparam int PROD_BITS = COORD_BITS + W_BITS;
    localparam int ACC_BITS  = PROD_BITS + 2;
    localparam int R_BITS    = ACC_BITS - FRACTION_BITS;
    localparam logic signed [W_BITS-1:0] TWO_ONE = W_BITS'(1) << (FRACTION_BITS + 1);
    localparam logic [ACC_BITS:0] ROUND_HALF = (ACC_BITS+1)'(1) << FRACTION_BITS;

    typedef logic signed [W_BITS-1:0]    t_weight;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic signed [ACC_BITS-1:0]  t_acc;

    logic                          en;
    logic [2*FRACTION_BITS-1:0]    sq;
    logic [2*FRACTION_BITS-1:0]    cube;
    t_weight                       t2s;
    t_weight                       t3s;
    t_weight                       fs;
    t_weight [NUM_TAPS-1:0]        w;

    logic                          r_v1, r_v2, r_v3, r_v4, r_v5, r_out_valid;
    t_q_entry                      r1_e, r2_e;
    logic [FRACTION_BITS-1:0]      r1_t2, r2_t2, r2_t3;
    t_coord [NUM_TAPS-1:0]         r3_px, r3_py;
    t_weight [NUM_TAPS-1:0]        r3_w;
    logic                          r3_oor, r4_oor, r5_oor, r_out_oor;
    t_prod [NUM_TAPS-1:0]          r4_px, r4_py;
    t_acc                          r5_ax, r5_ay;
    t_coord                        r_out_x, r_out_y;

    // round to nearest, halves up, then clamp to the coordinate range
    function automatic t_coord round_sat(input t_acc a);
        logic [ACC_BITS:0]   biased;
        logic [R_BITS-1:0]   r;
        t_coord              res;
        biased = {a[ACC_BITS-1], a} + ROUND_HALF;
        r      = biased[ACC_BITS:FRACTION_BITS+1];
        if ((&r[R_BITS-1:COORD_BITS-1]) || !(|r[R_BITS-1:COORD_BITS-1])) begin
            res = r[COORD_BITS-1:0];
        end else if (r[R_BITS-1]) begin
            res = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    // whole pipe moves unless the output word is stuck
    assign en    = !r_out_valid || o_result.ready;
    assign o_pop = en && i_q_status.not_empty;

    // squares, cubes and weights
    assign sq   = i_entry.frac * i_entry.frac;
    assign cube = r1_t2 * r1_e.frac;

    always_comb begin
        t2s  = $signed({{(W_BITS-FRACTION_BITS){1'b0}}, r2_t2});
        t3s  = $signed({{(W_BITS-FRACTION_BITS){1'b0}}, r2_t3});
        fs   = $signed({{(W_BITS-FRACTION_BITS){1'b0}}, r2_e.frac});
        w[0] = (t2s <<< 1) - t3s - fs;
        w[1] = (t3s <<< 1) + t3s - ((t2s <<< 2) + t2s) + TWO_ONE;
        w[2] = (t2s <<< 2) + fs - ((t3s <<< 1) + t3s);
        w[3] = t3s - t2s;
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= o_pop;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_out_valid <= r_v5;
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_e   <= i_entry;
            r1_t2  <= sq[2*FRACTION_BITS-1:FRACTION_BITS];

            r2_e   <= r1_e;
            r2_t2  <= r1_t2;
            r2_t3  <= cube[2*FRACTION_BITS-1:FRACTION_BITS];

            r3_px  <= r2_e.px;
            r3_py  <= r2_e.py;
            r3_w   <= w;
            r3_oor <= r2_e.oor;

            for (int i = 0; i < NUM_TAPS; i++) begin
                r4_px[i] <= $signed(r3_px[i]) * $signed(r3_w[i]);
                r4_py[i] <= $signed(r3_py[i]) * $signed(r3_w[i]);
            end
            r4_oor <= r3_oor;

            r5_ax  <= ACC_BITS'($signed(r4_px[0])) + ACC_BITS'($signed(r4_px[1]))
                    + ACC_BITS'($signed(r4_px[2])) + ACC_BITS'($signed(r4_px[3]));
            r5_ay  <= ACC_BITS'($signed(r4_py[0])) + ACC_BITS'($signed(r4_py[1]))
                    + ACC_BITS'($signed(r4_py[2])) + ACC_BITS'($signed(r4_py[3]));
            r5_oor <= r4_oor;

            // out-of-range segments report zero
            if (r5_oor) begin
                r_out_x <= '0;
                r_out_y <= '0;
            end else begin
                r_out_x <= round_sat(r5_ax);
                r_out_y <= round_sat(r5_ay);
            end
            r_out_oor <= r5_oor;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.curve_x      = r_out_x;
    assign o_result.curve_y      = r_out_y;
    assign o_result.out_of_range = r_out_oor;

endmodule

FILE: rtl/catmull_rom_point_eval_unit.sv
// top level of the uniform catmull-rom point evaluator
//
//  channel   dir  handshake      word
//  i_item    in   valid/ready    operation, point_index, point_x, point_y, curve_param
//  o_result  out  valid/ready    curve_x, curve_y, out_of_range (evaluate items only)
//  i_cfg     in   valid/ready    point_count, ready always high
//
// one item per cycle sustained while the queue has room; an evaluate result passes through
// (bank read, queue, six back stages set by the two fraction multiplies in series,
// tap multiply and sum). writes give no result.
// reset sets point count 4, clears valids and queue; point table holds garbage until written.
// a stalled output freezes the back pipe; the front keeps taking items until the
// four-entry queue is full.
module catmull_rom_point_eval_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crpe_in_if.sink   i_item,
    crpe_cfg_if.sink  i_cfg,
    crpe_out_if.source o_result
);
    import crpe_pkg::*;

    logic      push;
    logic      pop;
    t_q_entry  front_entry;
    t_q_entry  back_entry;
    t_q_status q_status;

    // accept, table and range check
    crpe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg      (i_cfg),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (front_entry)
    );

    // decoupling queue
    crpe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_entry  (back_entry),
        .o_status (q_status)
    );

    // arithmetic pipe and output word
    crpe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_entry    (back_entry),
        .o_pop      (pop),
        .o_result   (o_result)
    );

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench of the catmull-rom point evaluator: directed and random items
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crpe_pkg::*;

    // one input word as the sender drives it
    typedef struct {
        t_op                     op;
        logic [IDX_BITS-1:0]     idx;
        t_coord                  px;
        t_coord                  py;
        logic [PARAM_BITS-1:0]   param;
    } t_item_word;

    // one result word as predicted
    typedef struct {
        t_coord cx;
        t_coord cy;
        logic   oor;
    } t_curve_word;

    localparam int     DRAIN_CYCLES   = 16;
    localparam int     END_WAIT_LIMIT = 4000;
    localparam int     PHASES         = 12;
    localparam int     PHASE_ITEMS    = 130;
    localparam t_coord COORD_MAX      = t_coord'((1 << (COORD_BITS - 1)) - 1);
    localparam t_coord COORD_MIN      = -COORD_MAX - 1;

    // point counts of the random phases, extremes and out-of-contract values among them
    localparam logic [COUNT_BITS-1:0] PHASE_COUNTS [PHASES] = '{
        5'd16, 5'd4, 5'd31, 5'd0, 5'd9, 5'd16, 5'd3, 5'd17, 5'd12, 5'd5, 5'd16, 5'd7
    };

    logic clk;
    logic rst_n;

    crpe_in_if  item_if ();
    crpe_cfg_if cfg_if ();
    crpe_out_if res_if ();

    catmull_rom_point_eval_unit u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    // shadow of the point table and the point count
    t_coord                pt_x [MAX_POINTS];
    t_coord                pt_y [MAX_POINTS];
    logic [COUNT_BITS-1:0] count_sh = POINT_COUNT_RESET;

    t_curve_word curve_q [$];

    int unsigned mismatches = 0;
    int unsigned n_writes   = 0;
    int unsigned n_evals    = 0;
    int unsigned n_oor      = 0;
    int unsigned n_sat      = 0;
    int unsigned n_cfg      = 0;
    int unsigned src_calm   = 0;
    int unsigned sink_calm  = 0;

    // clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // idle cycles before a word: mostly a random gap, now and then a run with none
    function automatic int unsigned next_gap(inout int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(8, 48);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // round half up and clip to the coordinate range
    function automatic t_coord round_clip(longint acc);
        longint r;
        longint hi;
        hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        r  = (acc + (longint'(1) <<< FRACTION_BITS)) >>> (FRACTION_BITS + 1);
        if (r > hi) begin
            r = hi;
            n_sat++;
        end else if (r < -hi - 1) begin
            r = -hi - 1;
            n_sat++;
        end
        return t_coord'(r);
    endfunction

    // expected curve point for one curve parameter
    function automatic t_curve_word eval_curve(logic [PARAM_BITS-1:0] param);
        t_curve_word w;
        int          seg;
        int          n_eff;
        longint      f;
        longint      t2;
        longint      t3;
        longint      wt [NUM_TAPS];
        longint      ax;
        longint      ay;
        seg   = int'(param[PARAM_BITS-1:FRACTION_BITS]);
        f     = longint'(param[FRACTION_BITS-1:0]);
        n_eff = (int'(count_sh) > MAX_POINTS) ? MAX_POINTS : int'(count_sh);
        if (seg + NUM_TAPS > n_eff) begin
            w.cx  = '0;
            w.cy  = '0;
            w.oor = 1'b1;
            n_oor++;
            return w;
        end
        t2 = (f * f) >>> FRACTION_BITS;
        t3 = (t2 * f) >>> FRACTION_BITS;
        // doubled basis weights
        wt[0] = -t3 + 2 * t2 - f;
        wt[1] = 3 * t3 - 5 * t2 + (longint'(2) <<< FRACTION_BITS);
        wt[2] = -3 * t3 + 4 * t2 + f;
        wt[3] = t3 - t2;
        ax = 0;
        ay = 0;
        for (int i = 0; i < NUM_TAPS; i++) begin
            ax += longint'(pt_x[seg + i]) * wt[i];
            ay += longint'(pt_y[seg + i]) * wt[i];
        end
        w.cx  = round_clip(ax);
        w.cy  = round_clip(ay);
        w.oor = 1'b0;
        return w;
    endfunction

    // update the shadow table or queue the expected point for an accepted word
    task automatic apply_item(input t_item_word w);
        if (w.op == OP_WRITE) begin
            pt_x[w.idx] = w.px;
            pt_y[w.idx] = w.py;
            n_writes++;
        end else begin
            curve_q.push_back(eval_curve(w.param));
            n_evals++;
        end
    endtask

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 7))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic logic [PARAM_BITS-1:0] seg_frac(int seg, int frac);
        return PARAM_BITS'((seg << FRACTION_BITS) | frac);
    endfunction

    function automatic t_item_word write_word(int idx, t_coord x, t_coord y);
        t_item_word w;
        w.op    = OP_WRITE;
        w.idx   = IDX_BITS'(idx);
        w.px    = x;
        w.py    = y;
        w.param = PARAM_BITS'($urandom);
        return w;
    endfunction

    function automatic t_item_word eval_word(logic [PARAM_BITS-1:0] param);
        t_item_word w;
        w.op    = OP_EVAL;
        w.idx   = IDX_BITS'($urandom);
        w.px    = t_coord'($urandom);
        w.py    = t_coord'($urandom);
        w.param = param;
        return w;
    endfunction

    // parameter on a valid segment if the count has one, fraction extremes now and then
    function automatic logic [PARAM_BITS-1:0] inrange_param();
        int                       n_eff;
        logic [SEG_BITS-1:0]      seg;
        logic [FRACTION_BITS-1:0] frac;
        n_eff = (int'(count_sh) > MAX_POINTS) ? MAX_POINTS : int'(count_sh);
        if (n_eff >= NUM_TAPS) begin
            seg = SEG_BITS'($urandom_range(0, n_eff - NUM_TAPS));
        end else begin
            seg = SEG_BITS'($urandom);
        end
        case ($urandom_range(0, 9))
            0:       frac = '0;
            1:       frac = '1;
            2:       frac = FRACTION_BITS'(1 << (FRACTION_BITS - 1));
            default: frac = FRACTION_BITS'($urandom);
        endcase
        return {seg, frac};
    endfunction

    // send one word; called in the time step right after a rising edge
    task automatic send_item(input t_item_word w);
        int unsigned gap;
        gap = next_gap(src_calm);
        if (gap != 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid       <= 1'b1;
        item_if.operation   <= w.op;
        item_if.point_index <= w.idx;
        item_if.point_x     <= w.px;
        item_if.point_y     <= w.py;
        item_if.curve_param <= w.param;
        do @(posedge clk); while (item_if.ready !== 1'b1);
        apply_item(w);
    endtask

    // hold the sender until every expected point is back and the pipe is quiet
    task automatic drain_pipe();
        item_if.valid <= 1'b0;
        while (curve_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_point_count(input logic [COUNT_BITS-1:0] v);
        drain_pipe();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        count_sh = v;
        n_cfg++;
    endtask

    // reset count of four: segment 0 usable, higher segments flagged; both clip directions
    task automatic test_reset_count();
        send_item(write_word(0, COORD_MIN, COORD_MAX));
        send_item(write_word(1, COORD_MAX, COORD_MIN));
        send_item(write_word(2, COORD_MAX, COORD_MIN));
        send_item(write_word(3, COORD_MIN, COORD_MAX));
        send_item(eval_word(seg_frac(0, 0)));
        send_item(eval_word(seg_frac(0, 'h8000)));
        send_item(eval_word(seg_frac(0, 'hFFFF)));
        send_item(eval_word(seg_frac(1, 0)));
        send_item(eval_word('1));
    endtask

    // a write ignores the curve parameter, an evaluate ignores the point fields
    task automatic test_ignored_fields();
        t_item_word w;
        w       = write_word(3, t_coord'(16'sd100), t_coord'(-16'sd100));
        w.param = '1;
        send_item(w);
        w     = eval_word(seg_frac(0, 'h4000));
        w.idx = '1;
        w.px  = '1;
        w.py  = COORD_MIN;
        send_item(w);
        send_item(eval_word(seg_frac(0, 'hC000)));
    endtask

    // every slot holds a point before wider counts are used
    task automatic test_table_fill();
        for (int i = 0; i < MAX_POINTS; i++) begin
            send_item(write_word(i, rand_coord(), rand_coord()));
        end
    endtask

    // largest count, zero, below four, and counts beyond the table
    task automatic test_point_count_limits();
        set_point_count(COUNT_BITS'(MAX_POINTS));
        send_item(eval_word(seg_frac(MAX_POINTS - NUM_TAPS, 'hFFFF)));
        send_item(eval_word(seg_frac(MAX_POINTS - NUM_TAPS + 1, 0)));
        set_point_count('0);
        send_item(eval_word(seg_frac(0, 'h1234)));
        set_point_count(COUNT_BITS'(NUM_TAPS - 1));
        send_item(eval_word(seg_frac(0, 0)));
        set_point_count('1);
        send_item(eval_word(seg_frac(MAX_POINTS - NUM_TAPS, 'h0001)));
        send_item(eval_word(seg_frac(MAX_POINTS - NUM_TAPS + 1, 'h7FFF)));
        set_point_count(COUNT_BITS'(MAX_POINTS + 1));
        send_item(eval_word(seg_frac(MAX_POINTS - NUM_TAPS, 'h8000)));
    endtask

    // phases of mixed traffic, one point count each, with a full pause in some
    task automatic test_random_traffic();
        logic [COUNT_BITS-1:0] cnt;
        int unsigned           pick;
        for (int p = 0; p < PHASES; p++) begin
            cnt = PHASE_COUNTS[p];
            if (p == 9) begin
                cnt = COUNT_BITS'($urandom_range(NUM_TAPS + 1, MAX_POINTS - 1));
            end
            set_point_count(cnt);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p % 3 == 1 && i == PHASE_ITEMS / 2) begin
                    drain_pipe();
                end
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    send_item(write_word($urandom_range(0, MAX_POINTS - 1),
                                         rand_coord(), rand_coord()));
                end else if (pick < 25) begin
                    send_item(eval_word(PARAM_BITS'($urandom)));
                end else begin
                    send_item(eval_word(inrange_param()));
                end
            end
        end
    endtask

    // result side: random stalls, each word checked against the oldest prediction
    initial begin : result_sink
        int unsigned hold;
        t_curve_word want;
        hold = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_if.ready === 1'b1 && res_if.valid === 1'b1) begin
                if (curve_q.size() == 0) begin
                    $error("result word arrived with no point expected");
                    mismatches++;
                end else begin
                    want = curve_q.pop_front();
                    if (res_if.curve_x !== want.cx) begin
                        $error("curve_x expected %0d got %0d", want.cx, res_if.curve_x);
                        mismatches++;
                    end
                    if (res_if.curve_y !== want.cy) begin
                        $error("curve_y expected %0d got %0d", want.cy, res_if.curve_y);
                        mismatches++;
                    end
                    if (res_if.out_of_range !== want.oor) begin
                        $error("out_of_range expected %0d got %0d", want.oor,
                               res_if.out_of_range);
                        mismatches++;
                    end
                end
                hold = next_gap(sink_calm);
            end
            if (hold != 0) begin
                hold--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // main sequence
    initial begin : run
        int waited;
        rst_n               <= 1'b0;
        item_if.valid       <= 1'b0;
        item_if.operation   <= OP_WRITE;
        item_if.point_index <= '0;
        item_if.point_x     <= '0;
        item_if.point_y     <= '0;
        item_if.curve_param <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.data         <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_count();
        test_ignored_fields();
        test_table_fill();
        test_point_count_limits();
        test_random_traffic();

        // let the last points come back, bounded
        item_if.valid <= 1'b0;
        waited = 0;
        while (curve_q.size() != 0 && waited < END_WAIT_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (curve_q.size() != 0) begin
            $error("%0d expected points never arrived", curve_q.size());
            mismatches += curve_q.size();
        end

        $display("covered %0d point writes and %0d evaluations (%0d flagged out of range,",
                 n_writes, n_evals, n_oor);
        $display("  %0d clipped coordinates) across %0d point count settings", n_sat, n_cfg);
        if (mismatches == 0) begin
            $display("catmull_rom_point_eval_unit: match");
        end else begin
            $display("catmull_rom_point_eval_unit: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #5_000_000;
        $display("timeout waiting for the block");
        $display("catmull_rom_point_eval_unit: mismatch");
        $finish;
    end

endmodule
